FILE: rtl/imuac_pkg.sv
// Shared constants for the accelerometer activity classifier.
package imuac_pkg;

   // Window length default and register reset values (raw LSB and LSB squared scales).
   localparam int unsigned WINDOW_LEN_DEF = 32;

   localparam logic [15:0] FALL_THRESHOLD_RST = 16'd20492;
   localparam logic [29:0] STILL_LIMIT_RST    = 30'd3359312;
   localparam logic [29:0] WALK_LIMIT_RST     = 30'd33593120;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WALK_LIMIT     = 2'd2;

   localparam int unsigned CSR_DATA_W = 30;

   // Activity level codes.
   localparam logic [1:0] LEVEL_STILL = 2'd0;
   localparam logic [1:0] LEVEL_WALK  = 2'd1;
   localparam logic [1:0] LEVEL_RUN   = 2'd2;
   localparam logic [1:0] LEVEL_FALL  = 2'd3;

   // Temperature offsets, 4-bit two's complement.
   localparam logic signed [3:0] OFFSET_STILL = 4'sd0;
   localparam logic signed [3:0] OFFSET_WALK  = -4'sd3;
   localparam logic signed [3:0] OFFSET_RUN   = -4'sd6;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 88;

endpackage

FILE: rtl/imu_activity_classifier.sv
// Top level of the accelerometer windowed-variance activity classifier.
//
// Each accepted req transaction carries one signed 16-bit sample (x, y, z).
// The block forms the magnitude floor(sqrt(x^2+y^2+z^2)), writes it into a
// circular window of WINDOW_LEN entries, updates a running sum S1 and sum of
// squares S2, and reports the variance floor((W*S2 - S1^2)/W^2), saturated to
// 30 bits. A magnitude strictly above fall_threshold reports a fall (level 3,
// pulse and sticky flag set, offset and step count held). Otherwise a variance
// below still_variance_limit is still (offset 0), below walking_variance_limit
// is walking (offset -3, a positive-to-negative z crossing counts a step), else
// running (offset -6). One rsp transaction follows each req transaction.
// WINDOW_LEN must be a power of two (2 to 256), so the division by W^2 is a
// plain right shift.
// Sequence: the three axes are squared on the shared multiplier, 16 square
// root steps run on the shared compare-subtract unit, then come the window
// update, variance, commit and hand-off. While an earlier result still waits
// in the output register, the commit is held.
// req_tready is high only while the sequencer is idle. A finished result sits
// in the output register, so the next sample can be taken while rsp waits for
// rsp_tready. The window starts all zeros after reset with no clearing pass:
// entries not yet written since reset read as zero through a single wrap flag.
// Configuration writes are always accepted (csr_ready is tied high) and are to
// be issued while idle; an unknown index is ignored.
module imu_activity_classifier
   import imuac_pkg::*;
#(
   parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Sample channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] sample_x, [31:16] sample_y, [47:32] sample_z
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] magnitude, [45:16] window_variance, [47:46] activity_level,
   // [79:48] steps_total, [80] fall_pulse, [81] fall_sticky,
   // [85:82] temp_adjust, [87:86] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned CLOG_W = $clog2(WINDOW_LEN);
   localparam int unsigned AW     = CLOG_W;
   localparam int unsigned SUMW   = 16 + CLOG_W;
   localparam int unsigned SQW    = 32 + CLOG_W;
   localparam int unsigned NUMW   = 32 + 2 * CLOG_W;
   localparam int unsigned MULW   = SUMW;
   localparam int unsigned PRODW  = 2 * MULW;
   localparam logic [AW-1:0]   SLOT_LAST = AW'(WINDOW_LEN - 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_SQ    = 8'b00000010,
      ST_ROOT  = 8'b00000100,
      ST_OLD   = 8'b00001000,
      ST_NEW   = 8'b00010000,
      ST_SUMSQ = 8'b00100000,
      ST_DIFF  = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   // Sequencer and datapath registers.
   state_type state_ff, state_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic signed [15:0]     smp_x_ff, smp_x_in;
   logic signed [15:0]     smp_y_ff, smp_y_in;
   logic signed [15:0]     smp_z_ff, smp_z_in;
   logic [NUMW-1:0]        rem_ff, rem_in;
   logic [31:0]            root_ff, root_in;
   logic [31:0]            bit_ff, bit_in;
   logic [31:0]            quo_ff, quo_in;
   logic [PRODW-1:0]       den_ff, den_in;
   logic [NUMW-1:0]        wnum_ff, wnum_in;

   // Window and classifier state.
   logic [AW-1:0]          slot_ff, slot_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SUMW-1:0]        s1_ff, s1_in;
   logic [SQW-1:0]         s2_ff, s2_in;
   logic signed [15:0]     prev_z_ff, prev_z_in;
   logic [31:0]            steps_ff, steps_in;
   logic                   fall_ff, fall_in;
   logic signed [3:0]      offset_ff, offset_in;

   // Configuration registers.
   logic [15:0]            fall_thr_ff, fall_thr_in;
   logic [29:0]            still_lim_ff, still_lim_in;
   logic [29:0]            walk_lim_ff, walk_lim_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // Shared units.
   logic [MULW-1:0]        mul_a;
   logic [PRODW-1:0]       mul_p;
   logic [NUMW-1:0]        sub_a, sub_b;
   logic [NUMW:0]          sub_d;
   logic                   sub_ok;

   logic                   req_fire, csr_fire, out_free;
   logic [15:0]            axis_abs, old_mag, mag, rd_data;
   logic [29:0]            var_sat;
   logic                   is_fall, is_still, is_walk, step_hit;
   logic [1:0]             level;
   logic                   ram_wr_en;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mag     = root_ff[15:0];
   assign old_mag = wrapped_ff ? rd_data : 16'd0;
   assign ram_wr_en = (state_ff == ST_NEW);

   imuac_ram #(
      .WIDTH (16),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (mag),
      .rd_en   (req_fire),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // Pick the axis to square and take its absolute value.
   always_comb begin
      logic signed [15:0] axis;
      case (cnt_ff[1:0])
         2'd0:    axis = smp_x_ff;
         2'd1:    axis = smp_y_ff;
         default: axis = smp_z_ff;
      endcase
      axis_abs = axis[15] ? 16'(-axis) : 16'(axis);
   end

   // Operand selection for the shared multiplier and compare-subtract unit.
   always_comb begin
      mul_a = '0;
      sub_a = rem_ff;
      sub_b = '0;
      case (state_ff)
         ST_SQ:    mul_a = MULW'(axis_abs);
         ST_ROOT:  sub_b = NUMW'(root_ff + bit_ff);
         ST_OLD:   mul_a = MULW'(old_mag);
         ST_NEW:   mul_a = MULW'(mag);
         ST_SUMSQ: mul_a = s1_ff;
         ST_DIFF: begin
            sub_a = wnum_ff;
            sub_b = NUMW'(den_ff);
         end
         default:  mul_a = '0;
      endcase
   end

   assign mul_p  = mul_a * mul_a;
   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ok = !sub_d[NUMW];

   // Classification of the finished item.
   assign var_sat  = (quo_ff[31:30] != 2'b00) ? '1 : quo_ff[29:0];
   assign is_fall  = mag > fall_thr_ff;
   assign is_still = var_sat < still_lim_ff;
   assign is_walk  = var_sat < walk_lim_ff;
   assign step_hit = !prev_z_ff[15] && (prev_z_ff != 16'sd0) && smp_z_ff[15];

   always_comb begin
      if (is_fall) begin
         level = LEVEL_FALL;
      end else if (is_still) begin
         level = LEVEL_STILL;
      end else if (is_walk) begin
         level = LEVEL_WALK;
      end else begin
         level = LEVEL_RUN;
      end
   end

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      smp_x_in     = smp_x_ff;
      smp_y_in     = smp_y_ff;
      smp_z_in     = smp_z_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      wnum_in      = wnum_ff;
      slot_in      = slot_ff;
      wrapped_in   = wrapped_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      prev_z_in    = prev_z_ff;
      steps_in     = steps_ff;
      fall_in      = fall_ff;
      offset_in    = offset_ff;
      fall_thr_in  = fall_thr_ff;
      still_lim_in = still_lim_ff;
      walk_lim_in  = walk_lim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_fire) begin
         case (csr_index)
            CSR_FALL_THRESHOLD: fall_thr_in  = csr_data[15:0];
            CSR_STILL_LIMIT:    still_lim_in = csr_data[29:0];
            CSR_WALK_LIMIT:     walk_lim_in  = csr_data[29:0];
            default:            fall_thr_in  = fall_thr_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Latch the sample; the window read of the slot starts here.
            if (req_fire) begin
               smp_x_in = req_tdata[15:0];
               smp_y_in = req_tdata[31:16];
               smp_z_in = req_tdata[47:32];
               rem_in   = '0;
               cnt_in   = 5'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            // Accumulate x^2 + y^2 + z^2, one axis a cycle.
            rem_in = rem_ff + NUMW'(mul_p);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff[1:0] == 2'd2) begin
               root_in  = '0;
               bit_in   = 32'h4000_0000;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // One result bit of the square root a cycle.
            if (sub_ok) begin
               rem_in  = sub_d[NUMW-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_OLD;
            end
         end
         ST_OLD: begin
            // Retire the oldest magnitude from both sums and add the new one to S1.
            s1_in    = s1_ff - SUMW'(old_mag) + SUMW'(mag);
            s2_in    = s2_ff - SQW'(mul_p);
            state_in = ST_NEW;
         end
         ST_NEW: begin
            // Add the new magnitude's square to S2; the window write happens this cycle.
            s2_in = s2_ff + SQW'(mul_p);
            if (slot_ff == SLOT_LAST) begin
               slot_in    = '0;
               wrapped_in = 1'b1;
            end else begin
               slot_in = slot_ff + AW'(1);
            end
            state_in = ST_SUMSQ;
         end
         ST_SUMSQ: begin
            den_in   = mul_p;
            wnum_in  = NUMW'(s2_ff) * NUMW'(WINDOW_LEN);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // Clamp a negative numerator to zero, then divide by W^2 with a shift.
            quo_in   = sub_ok ? sub_d[NUMW-1:2*CLOG_W] : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free, then commit and publish.
            if (out_free) begin
               if (is_fall) begin
                  fall_in = 1'b1;
               end else if (is_still) begin
                  offset_in = OFFSET_STILL;
               end else if (is_walk) begin
                  offset_in = OFFSET_WALK;
                  if (step_hit) begin
                     steps_in = steps_ff + 32'd1;
                  end
                  prev_z_in = smp_z_ff;
               end else begin
                  offset_in = OFFSET_RUN;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, offset_in, fall_in, is_fall, steps_in, level,
                               var_sat, mag};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         wrapped_ff   <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         prev_z_ff    <= '0;
         steps_ff     <= '0;
         fall_ff      <= 1'b0;
         offset_ff    <= OFFSET_STILL;
         fall_thr_ff  <= FALL_THRESHOLD_RST;
         still_lim_ff <= STILL_LIMIT_RST;
         walk_lim_ff  <= WALK_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         wrapped_ff   <= wrapped_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         prev_z_ff    <= prev_z_in;
         steps_ff     <= steps_in;
         fall_ff      <= fall_in;
         offset_ff    <= offset_in;
         fall_thr_ff  <= fall_thr_in;
         still_lim_ff <= still_lim_in;
         walk_lim_ff  <= walk_lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      smp_x_ff    <= smp_x_in;
      smp_y_ff    <= smp_y_in;
      smp_z_ff    <= smp_z_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      wnum_ff     <= wnum_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // An accepted sample blocks the input until its result is committed.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted transaction");

   // A new result appears only from the commit state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result published outside the commit state");

   // The fall pulse marks exactly the fall level and implies the sticky flag.
   a_fall_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[80] == (rsp_tdata[47:46] == LEVEL_FALL))
                      && (!rsp_tdata[80] || rsp_tdata[81])))
      else $error("fall pulse, level and sticky flag disagree");

   // The still level always reports a zero offset.
   a_still_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[47:46] == LEVEL_STILL) |-> (rsp_tdata[85:82] == 4'd0))
      else $error("still level with nonzero temperature offset");

   // The write slot stays inside the window.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("window slot out of range");
`endif

endmodule

FILE: rtl/imuac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imuac_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/activity_checker.sv
// Scoreboard for the activity classifier: predicts every report and compares it on arrival.
module activity_checker
   import imuac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     reports_outstanding,
   output int                     mismatch_count
);

   localparam int unsigned WIN = WINDOW_LEN_DEF;
   localparam logic [29:0] VARIANCE_MAX = 30'h3FFF_FFFF;

   typedef struct {
      logic [15:0] magnitude;
      logic [29:0] variance;
      logic [1:0]  level;
      logic [31:0] steps;
      logic        pulse;
      logic        sticky;
      logic [3:0]  offset;
   } activity_report_type;

   activity_report_type predicted_reports[$];

   logic [15:0]        fall_limit;
   logic [29:0]        still_limit;
   logic [29:0]        walk_limit;
   logic [15:0]        mag_window [WIN];
   int unsigned        slot;
   logic [20:0]        mag_sum;
   logic [36:0]        mag_sum_sq;
   logic signed [15:0] last_z;
   logic [31:0]        steps_seen;
   logic               fall_flag;
   logic signed [3:0]  offset_now;
   int                 mismatches = 0;

   // Digit-by-digit floor square root; the sum of three squares stays below 2^32.
   function automatic logic [15:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] b;
      rem  = n;
      root = '0;
      for (int k = 16; k >= 0; k--) begin
         b = 64'd1 << (2 * k);
         if (rem >= root + b) begin
            rem  = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
      end
      return root[15:0];
   endfunction

   task automatic classify_sample(input logic [REQ_DATA_W-1:0] item);
      logic signed [15:0]  sx;
      logic signed [15:0]  sy;
      logic signed [15:0]  sz;
      longint unsigned     squares;
      longint unsigned     num;
      longint unsigned     den;
      longint unsigned     spread;
      longint unsigned     var_full;
      logic [15:0]         mag;
      logic [15:0]         old;
      activity_report_type r;
      sx = item[15:0];
      sy = item[31:16];
      sz = item[47:32];
      squares = longint'(sx) * longint'(sx) + longint'(sy) * longint'(sy)
              + longint'(sz) * longint'(sz);
      mag = floor_sqrt(squares);

      // Replace the oldest window entry and update the running sums.
      old = mag_window[slot];
      mag_sum = 21'(64'(mag_sum) - 64'(old) + 64'(mag));
      mag_sum_sq = 37'(64'(mag_sum_sq) - 64'(old) * 64'(old) + 64'(mag) * 64'(mag));
      mag_window[slot] = mag;
      slot = (slot + 1 >= WIN) ? 0 : slot + 1;

      num = 64'(WIN) * 64'(mag_sum_sq);
      den = 64'(mag_sum) * 64'(mag_sum);
      spread = (num >= den) ? num - den : 64'd0;
      var_full = spread / (64'(WIN) * 64'(WIN));
      if (var_full > VARIANCE_MAX)
         var_full = VARIANCE_MAX;

      r.magnitude = mag;
      r.variance  = var_full[29:0];
      r.pulse     = 1'b0;
      if (mag > fall_limit) begin
         // A fall holds the offset, the step count and the last z.
         r.level   = LEVEL_FALL;
         r.pulse   = 1'b1;
         fall_flag = 1'b1;
      end else if (var_full < still_limit) begin
         r.level    = LEVEL_STILL;
         offset_now = OFFSET_STILL;
      end else if (var_full < walk_limit) begin
         r.level    = LEVEL_WALK;
         offset_now = OFFSET_WALK;
         if (last_z > 0 && sz < 0)
            steps_seen = steps_seen + 32'd1;
         last_z = sz;
      end else begin
         r.level    = LEVEL_RUN;
         offset_now = OFFSET_RUN;
      end
      r.steps  = steps_seen;
      r.sticky = fall_flag;
      r.offset = offset_now;
      predicted_reports.push_back(r);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_report(input logic [RSP_DATA_W-1:0] word);
      activity_report_type want;
      if (predicted_reports.size() == 0) begin
         $error("rsp transaction with no sample pending: %h", word);
         mismatches++;
      end else begin
         want = predicted_reports.pop_front();
         check_field("magnitude", 32'(want.magnitude), 32'(word[15:0]));
         check_field("window_variance", 32'(want.variance), 32'(word[45:16]));
         check_field("activity_level", 32'(want.level), 32'(word[47:46]));
         check_field("steps_total", want.steps, word[79:48]);
         check_field("fall_pulse", 32'(want.pulse), 32'(word[80]));
         check_field("fall_sticky", 32'(want.sticky), 32'(word[81]));
         check_field("temp_adjust", 32'(want.offset), 32'(word[85:82]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fall_limit  = FALL_THRESHOLD_RST;
         still_limit = STILL_LIMIT_RST;
         walk_limit  = WALK_LIMIT_RST;
         for (int i = 0; i < WIN; i++)
            mag_window[i] = '0;
         slot        = 0;
         mag_sum     = '0;
         mag_sum_sq  = '0;
         last_z      = '0;
         steps_seen  = '0;
         fall_flag   = 1'b0;
         offset_now  = OFFSET_STILL;
         predicted_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FALL_THRESHOLD: fall_limit  = csr_data[15:0];
               CSR_STILL_LIMIT:    still_limit = csr_data;
               CSR_WALK_LIMIT:     walk_limit  = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            classify_sample(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_report(rsp_tdata);
      end
      reports_outstanding <= predicted_reports.size();
      mismatch_count      <= mismatches;
   end

endmodule

FILE: test/testbench.sv
// Testbench top for the activity classifier: drives samples, register writes and backpressure.
module testbench;
   import imuac_pkg::*;

   // Index with no register behind it; writes to it must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [29:0]            LIMIT_MAX  = 30'h3FFF_FFFF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 120;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int reports_outstanding;
   int mismatch_count;
   int idle_cycles = 0;
   bit quiet = 1'b0;   // set for the final stretch: no gaps, no stalls

   always #2 clock = ~clock;

   imu_activity_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   activity_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .reports_outstanding (reports_outstanding),
      .mismatch_count      (mismatch_count)
   );

   // Offer one sample and hold it until the req transaction completes. Leave
   // tvalid high afterwards; the next gap or drain lowers it.
   task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
      int unsigned gap;
      gap = 0;
      // Stack a few idle bursts so that gaps also outlast the block's busy time.
      if (!quiet && $urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 4)) gap += $urandom_range(1, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid and wait until every predicted report has been checked.
   // The first edge lets the checker count a sample accepted just now.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_outstanding != 0) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Write all three thresholds once the block has gone idle.
   task automatic configure(input logic [15:0] fall, input logic [29:0] still,
                            input logic [29:0] walk);
      drain();
      set_reg(CSR_FALL_THRESHOLD, {14'd0, fall});
      set_reg(CSR_STILL_LIMIT, still);
      set_reg(CSR_WALK_LIMIT, walk);
   endtask

   // One axis in [-amp, amp]; the widest setting covers the full 16-bit range.
   function automatic logic [15:0] axis_value(input int unsigned amp);
      int v;
      if (amp >= 32768)
         return 16'($urandom);
      v = int'($urandom_range(0, 2 * amp)) - int'(amp);
      return v[15:0];
   endfunction

   // Random samples in bursts of one motion intensity, so that the window
   // variance drifts across the still, walking and running bands.
   task automatic random_run(input int count);
      int unsigned amp;
      amp = 64;
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(0, 5))
               0:       amp = 64;
               1:       amp = 1500;
               2:       amp = 4000;
               3:       amp = 9000;
               4:       amp = 20000;
               default: amp = 32768;
            endcase
         end
         send_sample(axis_value(amp), axis_value(amp), axis_value(amp));
      end
   endtask

   // Receiver: random stall bursts between stretches of steady acceptance.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Watchdog: count cycles without any transaction on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [29:0] still_pick;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_FALL_THRESHOLD;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Window is all zeros after reset, so a lone magnitude of 32 gives a
      // variance of exactly 31. Variance equal to the still limit: walking.
      set_reg(CSR_STILL_LIMIT, 30'd31);
      send_sample(16'd32, 16'd0, 16'd0);
      // Same variance again, now equal to the walking limit: running.
      drain();
      set_reg(CSR_STILL_LIMIT, 30'd0);
      set_reg(CSR_WALK_LIMIT, 30'd31);
      send_sample(16'd0, 16'd0, 16'd0);

      // Back to the reset thresholds. Write the fall threshold with junk in the
      // upper bits (only the low 16 count) and hit the unused index.
      drain();
      set_reg(CSR_FALL_THRESHOLD, {14'h3FFF, FALL_THRESHOLD_RST});
      set_reg(CSR_STILL_LIMIT, STILL_LIMIT_RST);
      set_reg(CSR_WALK_LIMIT, WALK_LIMIT_RST);
      set_reg(CSR_UNUSED, LIMIT_MAX);
      send_sample(16'd20492, 16'd0, 16'd0);     // equal to threshold: no fall
      send_sample(16'd20493, 16'd0, 16'd0);     // just above: fall
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'd0, 16'd0, 16'h8000);
      send_sample(16'hFFFF, 16'd1, 16'hFFFF);
      send_sample(16'd0, 16'd0, 16'd0);

      // Force walking and step through z crossings; a fall in the middle must
      // leave the last z alone, so the following negative z still counts.
      configure(16'd1000, 30'd0, LIMIT_MAX);
      send_sample(16'd0, 16'd0, 16'd100);
      send_sample(16'd0, 16'd0, -16'sd100);     // step
      send_sample(16'd0, 16'd0, -16'sd5);
      send_sample(16'd0, 16'd0, 16'd5);
      send_sample(16'd0, 16'd0, 16'd0);
      send_sample(16'd0, 16'd0, -16'sd5);       // from zero: no step
      send_sample(16'd0, 16'd0, 16'd200);
      send_sample(16'd0, 16'd0, -16'sd2000);    // fall
      send_sample(16'd0, 16'd0, -16'sd100);     // step against z of 200

      // Random phases over the threshold extremes and the reset values.
      configure(FALL_THRESHOLD_RST, STILL_LIMIT_RST, WALK_LIMIT_RST);
      random_run(260);
      configure(16'd0, 30'd0, 30'd0);
      random_run(120);
      configure(16'hFFFF, LIMIT_MAX, LIMIT_MAX);
      random_run(120);
      configure(16'hFFFF, 30'd0, LIMIT_MAX);
      random_run(300);
      repeat (2) begin
         still_pick = 30'($urandom_range(0, 4000000));
         configure(16'($urandom_range(8000, 65535)), still_pick,
                   still_pick + 30'($urandom_range(0, 40000000)));
         random_run(150);
      end

      // Final stretch at full rate on both sides.
      quiet = 1'b1;
      still_pick = 30'($urandom_range(0, 4000000));
      configure(16'($urandom_range(8000, 65535)), still_pick,
                still_pick + 30'($urandom_range(0, 40000000)));
      random_run(300);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
